// File: hdl/assert_macros.svh
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define SGNS_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");

// Property checked at every rising clock edge, reset included.
`define SGNS_ASSERT_NR(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("assertion failed");

`endif

// File: hdl/sgns_pkg.sv
// ----------------------------------------------------------------------------
// sgns_pkg
// Types and fixed constants of the embedding update engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgns_pkg;

  localparam int unsigned ID_W      = 10;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned PRED_W    = 18;
  localparam int unsigned GRAD_W    = 19;
  localparam int unsigned QUOT_W    = 16;
  localparam int unsigned RED_STEPS = 10;

  typedef enum logic [2:0] {
    OP_TRAIN  = 3'd0,
    OP_WR_VTX = 3'd1,
    OP_WR_CTX = 3'd2,
    OP_RD_VTX = 3'd3,
    OP_RD_CTX = 3'd4
  } opcode_t;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_REDUCE = 14'b00000000000100,
    S_BASE   = 14'b00000000001000,
    S_IO     = 14'b00000000010000,
    S_IOWAIT = 14'b00000000100000,
    S_DOT    = 14'b00000001000000,
    S_SQUASH = 14'b00000010000000,
    S_DIV    = 14'b00000100000000,
    S_GRAD   = 14'b00001000000000,
    S_GWAIT  = 14'b00010000000000,
    S_ACC    = 14'b00100000000000,
    S_UPD    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: hdl/sgns_ram.sv
// ----------------------------------------------------------------------------
// sgns_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/sgns_mul.sv
// ----------------------------------------------------------------------------
// sgns_mul
// Shared signed 32 x 32 multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgns_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed      [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

`default_nettype wire

// File: hdl/sgns_div.sv
// ----------------------------------------------------------------------------
// sgns_div
// Restoring divider for the squash: quotient of mag*2^16 / (2^16 + mag).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgns_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [31:0]                      mag,
  output logic [sgns_pkg::QUOT_W-1:0]           quot,
  output sgns_pkg::div_stat_t                   stat
);

  logic [33:0] rem_r;
  logic [32:0] den_r;
  logic [sgns_pkg::QUOT_W-1:0] q_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [33:0] shl;
  logic [33:0] sub;
  logic        ge;

  // The quotient stays below 2^16, so the remainder starts at mag itself.
  assign shl = {rem_r[32:0], 1'b0};
  assign ge  = shl >= {1'b0, den_r};
  assign sub = shl - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(sgns_pkg::QUOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, mag};
      den_r <= (33'd1 << sgns_pkg::FRAC_W) + {1'b0, mag};
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? sub : shl;
      q_r   <= {q_r[sgns_pkg::QUOT_W-2:0], ge};
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// File: hdl/sgns_embedding_update.sv
// ----------------------------------------------------------------------------
// sgns_embedding_update
// Skip-gram negative-sampling SGD engine over vertex and context tables.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Contents
//   in_      input      in_valid/in_stall  opcode, row ids, label, rate, element
//   out_     output     out_valid/out_stall read value, prediction, saturated
//
// A train item makes three passes over the row through the one shared
// multiplier, plus ten row-reduce steps and sixteen divider steps for the
// squash. After reset the accumulator is cleared in a pass during which no
// item is accepted. A finished result sits in the output register, so the
// next item is taken while out_stall holds it; the engine only waits at the
// end of an item if the previous result is still held.
//
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sgns_embedding_update #(
  parameter int NUM_VERTICES = 1024,
  parameter int DIM          = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_opcode,
  input  wire logic [9:0]         in_vertex_id,
  input  wire logic [9:0]         in_context_id,
  input  wire logic               in_is_negative,
  input  wire logic               in_last_sample,
  input  wire logic [15:0]        in_learning_rate,
  input  wire logic [5:0]         in_elem_index,
  input  wire logic signed [31:0] in_write_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_read_value,
  output logic signed [17:0]      out_prediction,
  output logic                    out_saturated
);

  localparam int RW  = $clog2(NUM_VERTICES);
  localparam int AW  = $clog2(NUM_VERTICES * DIM);
  localparam int DIW = DIM > 1 ? $clog2(DIM) : 1;
  localparam int CW  = $clog2(DIM + 1);
  localparam int FW  = 48 + CW + 1;
  localparam int RDW = RW + sgns_pkg::ID_W;

  // Clamp to the 32-bit range; the top bit of the result flags a clamp.
  function automatic logic [32:0] clamp_w(input logic signed [FW-1:0] x);
    logic fits;
    fits = (x[FW-1:31] == '0) || (x[FW-1:31] == '1);
    if (fits) clamp_w = {1'b0, x[31:0]};
    else if (x[FW-1]) clamp_w = {1'b1, 32'h8000_0000};
    else clamp_w = {1'b1, 32'h7FFF_FFFF};
  endfunction

  sgns_pkg::state_t state_r, state_nxt;

  // Item fields held for the duration of the item.
  logic [2:0]  op_r;
  logic [sgns_pkg::ID_W-1:0] vred_r, cred_r;
  logic        neg_r, last_r;
  logic [15:0] rate_r;
  logic [5:0]  elem_r;
  logic signed [31:0] wval_r;

  logic [3:0]    k_r;
  logic [AW-1:0] vbase_r, cbase_r;
  logic [CW-1:0] iss_r, clr_r;
  logic          s1_v_r, s2_v_r;
  logic [DIW-1:0] s1_d_r, s2_d_r;
  logic signed [31:0] a_hold_r, c_hold_r, v_hold_r;
  logic signed [FW-1:0] f_r;
  logic          fneg_r;
  logic signed [sgns_pkg::GRAD_W-1:0] g_r;
  logic signed [sgns_pkg::PRED_W-1:0] pred_r;
  logic          sat_r;
  logic signed [31:0] rd_r;

  logic               out_valid_r;
  logic signed [31:0] out_rd_r;
  logic signed [17:0] out_pred_r;
  logic               out_sat_r;

  logic accept, out_load, in_pass, issue, pass_end, elem_ok;

  logic signed [31:0] vdout, cdout, adout;
  logic [AW-1:0]  v_raddr, c_raddr, v_waddr, c_waddr;
  logic           v_we, c_we, acc_we;
  logic [31:0]    v_wdata, c_wdata, acc_wdata;
  logic [DIW-1:0] acc_waddr;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] rnd_full;
  logic signed [47:0] rnd;
  logic signed [FW-1:0] rnd_w;
  logic [32:0] f_cl, acc_cl, ctx_cl, vtx_cl;
  logic [31:0] mag;
  logic signed [sgns_pkg::GRAD_W-1:0] diff;

  logic [sgns_pkg::QUOT_W-1:0] quot;
  sgns_pkg::div_stat_t div_stat;

  logic [RDW-1:0] v_step, c_step;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != sgns_pkg::S_IDLE;
  assign out_load = (state_r == sgns_pkg::S_DONE) && (!out_valid_r || !out_stall);
  assign in_pass  = (state_r == sgns_pkg::S_DOT) || (state_r == sgns_pkg::S_ACC) ||
                    (state_r == sgns_pkg::S_UPD);
  assign issue    = in_pass && (iss_r < CW'(DIM));
  assign pass_end = s2_v_r && (s2_d_r == DIW'(DIM - 1));
  assign elem_ok  = 32'(elem_r) < DIM;

  // Products of two Q16.16 words come back to Q16.16 with round-half-up.
  assign rnd_full = prod + 64'sd32768;
  assign rnd      = rnd_full[63:16];
  assign rnd_w    = FW'(rnd);

  assign f_cl   = clamp_w(f_r);
  assign acc_cl = clamp_w(FW'(a_hold_r) + rnd_w);
  assign ctx_cl = clamp_w(FW'(c_hold_r) + rnd_w);
  assign vtx_cl = clamp_w(FW'(v_hold_r) + FW'(a_hold_r));
  assign mag    = f_cl[31] ? (~f_cl[31:0] + 32'd1) : f_cl[31:0];

  // Label minus prediction, label being 1.0 for a positive context.
  assign diff = (neg_r ? 19'sd0 : 19'sd65536) - 19'(pred_r);

  // Restoring reduction of the row ids modulo the table height.
  assign v_step = RDW'(NUM_VERTICES) << k_r;
  assign c_step = RDW'(NUM_VERTICES) << k_r;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = vdout;
    mul_b = cdout;
    unique case (state_r)
      sgns_pkg::S_GRAD: begin
        mul_a = 32'(diff);
        mul_b = $signed({16'd0, rate_r});
      end
      sgns_pkg::S_ACC: begin
        mul_a = 32'(g_r);
        mul_b = cdout;
      end
      sgns_pkg::S_UPD: begin
        mul_a = 32'(g_r);
        mul_b = vdout;
      end
      default: begin
        mul_a = vdout;
        mul_b = cdout;
      end
    endcase
  end

  // Table ports: element accesses in S_IO, row sweeps in the passes.
  always_comb begin
    v_raddr   = vbase_r + AW'(iss_r);
    c_raddr   = cbase_r + AW'(iss_r);
    v_waddr   = vbase_r + AW'(s2_d_r);
    c_waddr   = cbase_r + AW'(s2_d_r);
    v_wdata   = vtx_cl[31:0];
    c_wdata   = ctx_cl[31:0];
    v_we      = s2_v_r && (state_r == sgns_pkg::S_UPD) && last_r;
    c_we      = s2_v_r && (state_r == sgns_pkg::S_UPD);
    acc_we    = (state_r == sgns_pkg::S_CLEAR) ||
                (s2_v_r && ((state_r == sgns_pkg::S_ACC) ||
                            ((state_r == sgns_pkg::S_UPD) && last_r)));
    acc_waddr = (state_r == sgns_pkg::S_CLEAR) ? DIW'(clr_r) : s2_d_r;
    acc_wdata = (state_r == sgns_pkg::S_ACC) ? acc_cl[31:0] : 32'd0;
    if (state_r == sgns_pkg::S_IO) begin
      v_raddr = vbase_r + AW'(elem_r);
      c_raddr = cbase_r + AW'(elem_r);
      v_waddr = vbase_r + AW'(elem_r);
      c_waddr = cbase_r + AW'(elem_r);
      v_wdata = wval_r;
      c_wdata = wval_r;
      v_we    = (op_r == sgns_pkg::OP_WR_VTX) && elem_ok;
      c_we    = (op_r == sgns_pkg::OP_WR_CTX) && elem_ok;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sgns_pkg::S_CLEAR:  if (clr_r == CW'(DIM - 1)) state_nxt = sgns_pkg::S_IDLE;
      sgns_pkg::S_IDLE:   if (accept) state_nxt = sgns_pkg::S_REDUCE;
      sgns_pkg::S_REDUCE: if (k_r == 4'd0) state_nxt = sgns_pkg::S_BASE;
      sgns_pkg::S_BASE: begin
        state_nxt = (op_r == sgns_pkg::OP_TRAIN) ? sgns_pkg::S_DOT : sgns_pkg::S_IO;
      end
      sgns_pkg::S_IO:     state_nxt = sgns_pkg::S_IOWAIT;
      sgns_pkg::S_IOWAIT: state_nxt = sgns_pkg::S_DONE;
      sgns_pkg::S_DOT:    if (pass_end) state_nxt = sgns_pkg::S_SQUASH;
      sgns_pkg::S_SQUASH: state_nxt = sgns_pkg::S_DIV;
      sgns_pkg::S_DIV:    if (div_stat.done) state_nxt = sgns_pkg::S_GRAD;
      sgns_pkg::S_GRAD:   state_nxt = sgns_pkg::S_GWAIT;
      sgns_pkg::S_GWAIT:  state_nxt = sgns_pkg::S_ACC;
      sgns_pkg::S_ACC:    if (pass_end) state_nxt = sgns_pkg::S_UPD;
      sgns_pkg::S_UPD:    if (pass_end) state_nxt = sgns_pkg::S_DONE;
      sgns_pkg::S_DONE:   if (out_load) state_nxt = sgns_pkg::S_IDLE;
      default:            state_nxt = sgns_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgns_pkg::S_CLEAR;
      clr_r       <= '0;
      iss_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sgns_pkg::S_CLEAR) begin
        clr_r <= clr_r + CW'(1);
      end
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      if (issue) begin
        iss_r <= iss_r + CW'(1);
      end else if (pass_end || (state_r == sgns_pkg::S_IDLE)) begin
        iss_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    s1_d_r   <= DIW'(iss_r);
    s2_d_r   <= s1_d_r;
    a_hold_r <= adout;
    c_hold_r <= cdout;
    v_hold_r <= vdout;

    if (accept) begin
      op_r   <= in_opcode;
      vred_r <= in_vertex_id;
      cred_r <= in_context_id;
      neg_r  <= in_is_negative;
      last_r <= in_last_sample;
      rate_r <= in_learning_rate;
      elem_r <= in_elem_index;
      wval_r <= in_write_value;
      k_r    <= 4'(sgns_pkg::RED_STEPS - 1);
      f_r    <= '0;
      pred_r <= '0;
      sat_r  <= 1'b0;
      rd_r   <= '0;
    end

    if (state_r == sgns_pkg::S_REDUCE) begin
      if (RDW'(vred_r) >= v_step) vred_r <= sgns_pkg::ID_W'(RDW'(vred_r) - v_step);
      if (RDW'(cred_r) >= c_step) cred_r <= sgns_pkg::ID_W'(RDW'(cred_r) - c_step);
      k_r <= k_r - 4'd1;
    end

    if (state_r == sgns_pkg::S_BASE) begin
      vbase_r <= AW'(vred_r) * AW'(DIM);
      cbase_r <= AW'(cred_r) * AW'(DIM);
    end

    if (state_r == sgns_pkg::S_IOWAIT && elem_ok) begin
      if (op_r == sgns_pkg::OP_RD_VTX) rd_r <= vdout;
      else if (op_r == sgns_pkg::OP_RD_CTX) rd_r <= cdout;
    end

    if (state_r == sgns_pkg::S_DOT && s2_v_r) begin
      f_r <= f_r + rnd_w;
    end

    if (state_r == sgns_pkg::S_SQUASH) begin
      fneg_r <= f_cl[31];
      if (f_cl[32]) sat_r <= 1'b1;
    end

    if (state_r == sgns_pkg::S_DIV && div_stat.done) begin
      pred_r <= fneg_r ? -sgns_pkg::PRED_W'(quot) : sgns_pkg::PRED_W'(quot);
    end

    if (state_r == sgns_pkg::S_GWAIT) begin
      g_r <= rnd[sgns_pkg::GRAD_W-1:0];
    end

    if (state_r == sgns_pkg::S_ACC && s2_v_r && acc_cl[32]) begin
      sat_r <= 1'b1;
    end

    if (state_r == sgns_pkg::S_UPD && s2_v_r && (ctx_cl[32] || (last_r && vtx_cl[32]))) begin
      sat_r <= 1'b1;
    end

    if (out_load) begin
      out_rd_r   <= rd_r;
      out_pred_r <= pred_r;
      out_sat_r  <= sat_r;
    end
  end

  sgns_ram #(.WIDTH(32), .DEPTH(NUM_VERTICES * DIM)) u_vtx_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (vdout)
  );

  sgns_ram #(.WIDTH(32), .DEPTH(NUM_VERTICES * DIM)) u_ctx_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (cdout)
  );

  sgns_ram #(.WIDTH(32), .DEPTH(DIM)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (DIW'(iss_r)),
    .rdata (adout)
  );

  sgns_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  sgns_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == sgns_pkg::S_SQUASH),
    .mag   (mag),
    .quot  (quot),
    .stat  (div_stat)
  );

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_prediction = out_pred_r;
  assign out_saturated  = out_sat_r;

  // The accumulator is never written while the dot product is formed.
  `SGNS_ASSERT(a_no_acc_wr_in_dot, clk, rst_n, (state_r == sgns_pkg::S_DOT) |-> !acc_we)
  // A new result only appears out of the final state of an item.
  `SGNS_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == sgns_pkg::S_DONE))
  // The squashed score never reaches one in magnitude.
  `SGNS_ASSERT(a_pred_range, clk, rst_n, out_valid_r |-> ((out_prediction <= 18'sd65535) && (out_prediction >= -18'sd65535)))
  // Reset always starts the clearing pass, so no item is taken right after it.
  `SGNS_ASSERT_NR(a_stall_after_rst, clk, !rst_n |=> in_stall)

endmodule

`default_nettype wire

// File: test/sgns_embedding_update_tb.sv
// ----------------------------------------------------------------------------
// sgns_embedding_update_tb
// Self-checking bench for the skip-gram embedding update engine. A short
// table of directed element writes, reads and unknown opcodes runs first.
// A few rows are then loaded in full, and a random mix of training samples,
// writes, reads and unknown opcodes follows. Every result is compared with
// a cycle-free predictor that keeps its own copy of both tables and the
// error accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgns_embedding_update_tb;

  localparam int NROW      = 1024;
  localparam int NDIM      = 64;
  localparam int N_RANDOM  = 1550;
  localparam int IDLE_MAX  = 4000;
  localparam int DRAIN_CYC = 400;

  typedef struct {
    logic [2:0]         op;
    logic [9:0]         vid;
    logic [9:0]         cid;
    logic               neg;
    logic               last;
    logic [15:0]        rate;
    logic [5:0]         elem;
    logic signed [31:0] wval;
  } sample_t;

  typedef struct {
    logic signed [31:0] rd;
    logic signed [17:0] pred;
    logic               sat;
  } update_res_t;

  // One directed row: the item, and a typed answer where chk is set.
  typedef struct {
    sample_t     s;
    bit          chk;
    update_res_t r;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic [9:0] in_vertex_id = '0;
  logic [9:0] in_context_id = '0;
  logic in_is_negative = 1'b0;
  logic in_last_sample = 1'b0;
  logic [15:0] in_learning_rate = '0;
  logic [5:0] in_elem_index = '0;
  logic signed [31:0] in_write_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_read_value;
  logic signed [17:0] out_prediction;
  logic out_saturated;

  // Predictor state: both tables, their written marks, and the accumulator.
  int  vtx_tab [0:NROW*NDIM-1];
  int  ctx_tab [0:NROW*NDIM-1];
  bit  vtx_wr  [0:NROW*NDIM-1];
  bit  ctx_wr  [0:NROW*NDIM-1];
  int  err_acc [0:NDIM-1];
  int  vtx_addr_q[$];
  int  ctx_addr_q[$];

  update_res_t pending_q[$];
  int          n_errors = 0;
  int          idle_cycles = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  int          stall_left = 0;

  always #1 clk = ~clk;

  sgns_embedding_update u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_vertex_id     (in_vertex_id),
    .in_context_id    (in_context_id),
    .in_is_negative   (in_is_negative),
    .in_last_sample   (in_last_sample),
    .in_learning_rate (in_learning_rate),
    .in_elem_index    (in_elem_index),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_value   (out_read_value),
    .out_prediction   (out_prediction),
    .out_saturated    (out_saturated)
  );

  // Round a product carrying 16 extra fraction bits back to Q16.16.
  function automatic longint round_q16(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic int clamp_word(input longint x, inout bit sat);
    if (x > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return int'(x);
  endfunction

  // Advance the predictor by one accepted item and return its result.
  function automatic update_res_t sgd_update(input sample_t s);
    update_res_t r;
    int          vb;
    int          cb;
    int          fc;
    longint      f;
    longint      mag;
    longint      p;
    longint      g;
    bit          sat;
    r = '{rd: '0, pred: '0, sat: 1'b0};
    vb = int'(s.vid) * NDIM;
    cb = int'(s.cid) * NDIM;
    sat = 1'b0;
    case (s.op)
      sgns_pkg::OP_TRAIN: begin
        f = 0;
        for (int d = 0; d < NDIM; d++)
          f += round_q16(longint'(vtx_tab[vb+d]) * longint'(ctx_tab[cb+d]));
        fc = clamp_word(f, sat);
        mag = (fc < 0) ? -longint'(fc) : longint'(fc);
        p = (mag * 65536) / (65536 + mag);
        if (fc < 0)
          p = -p;
        g = round_q16(((s.neg ? 64'sd0 : 64'sd65536) - p) * longint'(s.rate));
        // The accumulator sees the context row before this item changes it.
        for (int d = 0; d < NDIM; d++)
          err_acc[d] = clamp_word(longint'(err_acc[d]) +
                                  round_q16(g * longint'(ctx_tab[cb+d])), sat);
        for (int d = 0; d < NDIM; d++)
          ctx_tab[cb+d] = clamp_word(longint'(ctx_tab[cb+d]) +
                                     round_q16(g * longint'(vtx_tab[vb+d])), sat);
        if (s.last) begin
          for (int d = 0; d < NDIM; d++) begin
            vtx_tab[vb+d] = clamp_word(longint'(vtx_tab[vb+d]) +
                                       longint'(err_acc[d]), sat);
            err_acc[d] = 0;
          end
        end
        r.pred = p[17:0];
        r.sat = sat;
      end
      sgns_pkg::OP_WR_VTX: begin
        vtx_tab[vb+s.elem] = s.wval;
        if (!vtx_wr[vb+s.elem])
          vtx_addr_q.push_back(vb + s.elem);
        vtx_wr[vb+s.elem] = 1'b1;
      end
      sgns_pkg::OP_WR_CTX: begin
        ctx_tab[cb+s.elem] = s.wval;
        if (!ctx_wr[cb+s.elem])
          ctx_addr_q.push_back(cb + s.elem);
        ctx_wr[cb+s.elem] = 1'b1;
      end
      sgns_pkg::OP_RD_VTX: r.rd = vtx_tab[vb+s.elem];
      sgns_pkg::OP_RD_CTX: r.rd = ctx_tab[cb+s.elem];
      default: ;
    endcase
    return r;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Element values: mostly within about half a unit, sometimes any word.
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $signed($urandom_range(0, 65535)) - 32768;
    if (r < 92)
      return $signed($urandom_range(0, 262143)) - 131072;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_rate();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)
      return 16'd0;
    if (r == 1)
      return 16'hffff;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Present one item, hold it until the block takes it, then predict.
  task automatic send_item(input sample_t s, input bit typed, input update_res_t tr);
    int          gap;
    update_res_t r;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= s.op;
    in_vertex_id     <= s.vid;
    in_context_id    <= s.cid;
    in_is_negative   <= s.neg;
    in_last_sample   <= s.last;
    in_learning_rate <= s.rate;
    in_elem_index    <= s.elem;
    in_write_value   <= s.wval;
    do
      @(posedge clk);
    while (!(in_valid && !in_stall));
    r = sgd_update(s);
    pending_q.push_back(typed ? tr : r);
  endtask

  // Result side: random stall runs, then a check of every taken result
  // against the oldest prediction still waiting.
  always @(posedge clk) begin : result_check
    update_res_t e;
    bit          took_in;
    bit          took_out;
    took_in = rst_n && in_valid && !in_stall;
    took_out = rst_n && out_valid && !out_stall;
    if (took_out) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: rd %0d pred %0d sat %0d",
               out_read_value, out_prediction, out_saturated);
        n_errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_read_value !== e.rd) begin
          $error("read_value expected %0d actual %0d", e.rd, out_read_value);
          n_errors++;
        end
        if (out_prediction !== e.pred) begin
          $error("prediction expected %0d actual %0d", e.pred, out_prediction);
          n_errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated expected %0d actual %0d", e.sat, out_saturated);
          n_errors++;
        end
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (rst_n && !calm_out)
        stall_left <= pick_gap(1'b0);
    end
    // Watchdog: too long without any item moving on either side.
    if (took_in || took_out || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_MAX) begin
      $display("tb: failure");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : stimulus
    vec_t        dir_tab[$];
    sample_t     s;
    update_res_t z;
    int          vpool[3];
    int          cpool[3];
    int          kind;
    int          a;
    z = '{rd: '0, pred: '0, sat: 1'b0};
    for (int i = 0; i < NROW*NDIM; i++) begin
      vtx_tab[i] = 0;
      ctx_tab[i] = 0;
      vtx_wr[i] = 1'b0;
      ctx_wr[i] = 1'b0;
    end
    for (int d = 0; d < NDIM; d++)
      err_acc[d] = 0;

    // Directed rows: extremes of ids, elements and values read straight
    // back, and unknown opcodes with every other field at all ones or all zeros.
    dir_tab = '{
      '{'{sgns_pkg::OP_WR_VTX, 10'd0, 10'd0, 1'b0, 1'b0, 16'd0, 6'd0, 32'sh7fffffff},
        1'b1, z},
      '{'{sgns_pkg::OP_RD_VTX, 10'd0, 10'd0, 1'b0, 1'b0, 16'd0, 6'd0, 32'sh0}, 1'b1,
        '{32'sh7fffffff, 18'sd0, 1'b0}},
      '{'{sgns_pkg::OP_WR_CTX, 10'd1023, 10'd1023, 1'b1, 1'b1, 16'hffff, 6'd63,
          32'sh80000000}, 1'b1, z},
      '{'{sgns_pkg::OP_RD_CTX, 10'd0, 10'd1023, 1'b0, 1'b0, 16'd0, 6'd63, 32'sh0}, 1'b1,
        '{32'sh80000000, 18'sd0, 1'b0}},
      '{'{3'd5, 10'h3ff, 10'h3ff, 1'b1, 1'b1, 16'hffff, 6'h3f, 32'shffffffff}, 1'b1, z},
      '{'{3'd6, 10'h3ff, 10'h3ff, 1'b1, 1'b1, 16'hffff, 6'h3f, 32'shffffffff}, 1'b1, z},
      '{'{3'd7, 10'h3ff, 10'h3ff, 1'b1, 1'b1, 16'hffff, 6'h3f, 32'shffffffff}, 1'b1, z},
      '{'{sgns_pkg::OP_WR_VTX, 10'd1023, 10'd0, 1'b0, 1'b0, 16'd0, 6'd63, 32'shffffffff},
        1'b1, z},
      '{'{sgns_pkg::OP_RD_VTX, 10'd1023, 10'd0, 1'b0, 1'b0, 16'd0, 6'd63, 32'sh0}, 1'b1,
        '{-32'sd1, 18'sd0, 1'b0}},
      '{'{sgns_pkg::OP_WR_CTX, 10'd0, 10'd0, 1'b0, 1'b0, 16'd0, 6'd0, 32'sh0}, 1'b1, z},
      '{'{sgns_pkg::OP_RD_CTX, 10'd0, 10'd0, 1'b0, 1'b0, 16'd0, 6'd0, 32'sh0}, 1'b1, z},
      '{'{sgns_pkg::OP_WR_VTX, 10'h155, 10'h2aa, 1'b0, 1'b0, 16'd0, 6'h15, 32'sh55555555},
        1'b1, z},
      '{'{sgns_pkg::OP_WR_CTX, 10'h155, 10'h2aa, 1'b0, 1'b0, 16'd0, 6'h2a, 32'shaaaaaaaa},
        1'b1, z},
      '{'{sgns_pkg::OP_RD_VTX, 10'h155, 10'h2aa, 1'b0, 1'b0, 16'd0, 6'h15, 32'sh0}, 1'b1,
        '{32'sh55555555, 18'sd0, 1'b0}},
      '{'{sgns_pkg::OP_RD_CTX, 10'h155, 10'h2aa, 1'b0, 1'b0, 16'd0, 6'h2a, 32'sh0}, 1'b1,
        '{32'shaaaaaaaa, 18'sd0, 1'b0}},
      '{'{3'd5, 10'd0, 10'd0, 1'b0, 1'b0, 16'd0, 6'd0, 32'sh0}, 1'b1, z}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      send_item(dir_tab[i].s, dir_tab[i].chk, dir_tab[i].r);

    // Load whole rows so that training only ever touches written entries.
    // Row 0 and row 1023 are in both pools, one random row beside them.
    vpool = '{0, 1023, $urandom_range(1, 1022)};
    cpool = '{0, 1023, $urandom_range(1, 1022)};
    for (int p = 0; p < 3; p++) begin
      for (int d = 0; d < NDIM; d++) begin
        s = '{sgns_pkg::OP_WR_VTX, vpool[p][9:0], 10'($urandom), 1'b0, 1'b0, 16'd0,
              d[5:0], pick_value()};
        send_item(s, 1'b0, z);
        s = '{sgns_pkg::OP_WR_CTX, 10'($urandom), cpool[p][9:0], 1'b0, 1'b0, 16'd0,
              d[5:0], pick_value()};
        send_item(s, 1'b0, z);
      end
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // Quiet stretches with no gaps and no stalls now and then.
      if (n % 150 == 0) begin
        calm_in = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 99);
      s = '{3'($urandom), 10'($urandom), 10'($urandom), 1'($urandom), 1'($urandom),
            pick_rate(), 6'($urandom), pick_value()};
      if (kind < 55) begin
        // Training sample on loaded rows; a context row may equal itself
        // across items, and groups end on a random last flag.
        s.op = sgns_pkg::OP_TRAIN;
        s.vid = vpool[$urandom_range(0, 2)][9:0];
        s.cid = cpool[$urandom_range(0, 2)][9:0];
        s.last = ($urandom_range(0, 3) == 0);
      end else if (kind < 65) begin
        // Refresh a pooled element so the rows do not drift into saturation.
        if ($urandom_range(0, 1) == 0) begin
          s.op = sgns_pkg::OP_WR_VTX;
          s.vid = vpool[$urandom_range(0, 2)][9:0];
        end else begin
          s.op = sgns_pkg::OP_WR_CTX;
          s.cid = cpool[$urandom_range(0, 2)][9:0];
        end
      end else if (kind < 77) begin
        s.op = ($urandom_range(0, 1) == 0) ? sgns_pkg::OP_WR_VTX : sgns_pkg::OP_WR_CTX;
        if ($urandom_range(0, 9) == 0)
          s.wval = $urandom;
      end else if (kind < 94) begin
        // Read back only entries that were written at some point.
        if ($urandom_range(0, 1) == 0) begin
          a = vtx_addr_q[$urandom_range(0, vtx_addr_q.size() - 1)];
          s.op = sgns_pkg::OP_RD_VTX;
          s.vid = 10'(a / NDIM);
        end else begin
          a = ctx_addr_q[$urandom_range(0, ctx_addr_q.size() - 1)];
          s.op = sgns_pkg::OP_RD_CTX;
          s.cid = 10'(a / NDIM);
        end
        s.elem = 6'(a % NDIM);
      end else begin
        s.op = 3'($urandom_range(5, 7));
      end
      send_item(s, 1'b0, z);
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
